### rtl/kllh_pkg.sv
// Package for the keyed latency log2 histogram unit.
// Holds the shared widths, constants, event codes and beat structs; no dependencies.
package kllh_pkg;

    localparam int TableEntriesDef = 64;
    localparam int HistBucketsDef  = 64;

    localparam int DataW   = 64;
    localparam int BucketW = 6;
    // Width that holds the nanoseconds in one microsecond.
    localparam int RemW    = 10;
    localparam logic [RemW:0] NsPerUs = (RemW + 1)'(1000);

    localparam logic KindStart = 1'b0;
    localparam logic KindStop  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [DataW-1:0] requester;
        logic [DataW-1:0] time_ns;
    } t_in;

    typedef struct packed {
        logic               stored;
        logic               table_full;
        logic               matched;
        logic [BucketW-1:0] bucket;
        logic [DataW-1:0]   bucket_count;
    } t_res;

    typedef struct packed {
        logic             valid;
        logic [DataW-1:0] key;
        logic [DataW-1:0] start_ns;
    } t_entry;

    typedef struct packed {
        logic               done;
        logic [BucketW-1:0] bucket;
    } t_div_stat;

endpackage

### rtl/kllh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module kllh_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kllh_div.sv
// Shift-and-compare search that yields the capped floor log2 of a 64-bit latency
// taken in microseconds. Depends on kllh_pkg.
module kllh_div import kllh_pkg::*; #(
    parameter int HistBuckets = HistBucketsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DataW-1:0] i_dividend,
    output t_div_stat        o_stat
);

    localparam logic [BucketW-1:0] LastBucket = BucketW'(HistBuckets - 1);
    localparam logic [DataW-1:0]   TwoUs      = DataW'(NsPerUs) << 1;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DataW-1:0]   r_val, n_val;
    logic [BucketW-1:0] r_pos, n_pos;
    logic               found;

    // After j halvings the value is floor(d / 2^j). It is at least 2000 exactly when
    // the quotient d / 1000 is at least 2^(j+1), so the first j that fails the test
    // is floor(log2) of the quotient, and a quotient of zero or one stops at j = 0.
    assign found = (r_val < TwoUs) || (r_pos == LastBucket);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_val  = r_val;
        n_pos  = r_pos;
        if (i_start) begin
            n_busy = 1'b1;
            n_val  = i_dividend;
            n_pos  = '0;
        end else if (r_busy) begin
            if (found) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_val = {1'b0, r_val[DataW-1:1]};
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pos <= n_pos;
    end

    always_comb begin
        o_stat.done   = r_done;
        o_stat.bucket = r_pos;
    end

endmodule

### rtl/keyed_latency_log2_histogram_unit.sv
// Top level of the keyed latency log2 histogram unit: sequencer, entry table and
// histogram memories, and the shift-and-compare bucket unit. Depends on
// kllh_pkg, kllh_ram and kllh_div.

// A start event stores its timestamp under its requester key; a stop event finds
// the key, frees the entry and counts the latency in microseconds into a log2
// histogram bucket. An event is taken when start is high and busy is low, and
// exactly one result beat follows on o_result, marked by o_strobe for a single
// cycle; the receiver cannot stall it, so it must take every beat. After reset
// the block runs a clearing pass over both memories, with busy high. Every event
// scans the whole key table through the memory's one registered read port, one
// entry per cycle, and then updates the table; a start event or an unmatched stop
// shows its beat after that update. A matched stop then searches for its bucket
// with one shift and one compare per cycle, halving the latency until its quotient
// by 1000 falls below two or the last bucket is reached, and ends with a
// read-modify-write of the bucket counter before its beat shows. The bucket
// counted is at most 54 for a 64-bit latency. Busy falls on the cycle the result
// beat is shown.
module keyed_latency_log2_histogram_unit import kllh_pkg::*; #(
    parameter int TableEntries = TableEntriesDef,
    parameter int HistBuckets  = HistBucketsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_strobe,
    output t_res o_result
);

    localparam int EntW = $bits(t_entry);
    localparam int EAW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int HAW  = (HistBuckets > 1) ? $clog2(HistBuckets) : 1;
    localparam int ClrN = (TableEntries > HistBuckets) ? TableEntries : HistBuckets;
    localparam int CntW = $clog2(ClrN + 1);

    localparam logic [CntW-1:0] CntTe   = CntW'(TableEntries);
    localparam logic [CntW-1:0] CntHb   = CntW'(HistBuckets);
    localparam logic [CntW-1:0] CntLast = CntW'(ClrN - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_HRD   = 3'd5;
    localparam logic [2:0] S_HUPD  = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic               r_free, n_free;
    logic               r_strobe, n_strobe;
    t_in                r_in, n_in;
    logic [EAW-1:0]     r_cmp_idx, n_cmp_idx;
    logic [EAW-1:0]     r_hit_idx, n_hit_idx;
    logic [DataW-1:0]   r_hit_start, n_hit_start;
    logic [EAW-1:0]     r_free_idx, n_free_idx;
    logic [BucketW-1:0] r_bucket, n_bucket;
    t_res               r_res, n_res;

    logic               ent_we;
    logic [EAW-1:0]     ent_waddr;
    t_entry             ent_wdata;
    logic [EntW-1:0]    ent_rdata;
    t_entry             ent_rd;
    logic               hist_we;
    logic [HAW-1:0]     hist_waddr;
    logic [DataW-1:0]   hist_wdata;
    logic [DataW-1:0]   hist_rdata;
    logic               div_go;
    logic [DataW-1:0]   div_dividend;
    t_div_stat          div_stat;
    logic               cmp_act;
    logic [DataW-1:0]   cnt_inc;

    // Key table: valid flag, key and start timestamp per entry.
    kllh_ram #(
        .Width(EntW),
        .Depth(TableEntries)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(ent_waddr),
        .i_wdata(ent_wdata),
        .i_raddr(r_cnt[EAW-1:0]),
        .o_rdata(ent_rdata)
    );

    assign ent_rd = t_entry'(ent_rdata);

    // Histogram counters, read and written back once per matched stop.
    kllh_ram #(
        .Width(DataW),
        .Depth(HistBuckets)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(r_bucket[HAW-1:0]),
        .o_rdata(hist_rdata)
    );

    // The wrapping difference of the timestamps feeds the bucket search as it starts.
    assign div_dividend = r_in.time_ns - r_hit_start;

    kllh_div #(
        .HistBuckets(HistBuckets)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_go),
        .i_dividend(div_dividend),
        .o_stat    (div_stat)
    );

    // Read data is registered behind the scan address, so the first scan cycle has
    // nothing to compare yet.
    assign cmp_act = (r_state == S_SCAN) && (r_cnt != '0);
    assign cnt_inc = hist_rdata + DataW'(1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_free      = r_free;
        n_strobe    = 1'b0;
        n_in        = r_in;
        n_cmp_idx   = r_cnt[EAW-1:0];
        n_hit_idx   = r_hit_idx;
        n_hit_start = r_hit_start;
        n_free_idx  = r_free_idx;
        n_bucket    = r_bucket;
        n_res       = r_res;
        ent_we      = 1'b0;
        ent_waddr   = r_cnt[EAW-1:0];
        ent_wdata   = '0;
        hist_we     = 1'b0;
        hist_waddr  = r_bucket[HAW-1:0];
        hist_wdata  = '0;
        div_go      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ent_we     = (r_cnt < CntTe);
                hist_we    = (r_cnt < CntHb);
                hist_waddr = r_cnt[HAW-1:0];
                if (r_cnt == CntLast) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_in    = i_item;
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_act) begin
                    if (ent_rd.valid && (ent_rd.key == r_in.requester) && !r_hit) begin
                        n_hit       = 1'b1;
                        n_hit_idx   = r_cmp_idx;
                        n_hit_start = ent_rd.start_ns;
                    end
                    if (!ent_rd.valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                end
                if (r_cnt == CntTe) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                n_res = '0;
                if (r_in.kind == KindStart) begin
                    ent_wdata.valid    = 1'b1;
                    ent_wdata.key      = r_in.requester;
                    ent_wdata.start_ns = r_in.time_ns;
                    if (r_hit) begin
                        ent_we       = 1'b1;
                        ent_waddr    = r_hit_idx;
                        n_res.stored = 1'b1;
                    end else if (r_free) begin
                        ent_we       = 1'b1;
                        ent_waddr    = r_free_idx;
                        n_res.stored = 1'b1;
                    end else begin
                        n_res.table_full = 1'b1;
                    end
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_hit) begin
                    // Free the entry and start the bucket search on the latency.
                    ent_we    = 1'b1;
                    ent_waddr = r_hit_idx;
                    div_go    = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_bucket = div_stat.bucket;
                    n_state  = S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HUPD;
            end
            S_HUPD: begin
                hist_we            = 1'b1;
                hist_wdata         = cnt_inc;
                n_res              = '0;
                n_res.matched      = 1'b1;
                n_res.bucket       = r_bucket;
                n_res.bucket_count = cnt_inc;
                n_strobe           = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_hit    <= n_hit;
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_cmp_idx   <= n_cmp_idx;
        r_hit_idx   <= n_hit_idx;
        r_hit_start <= n_hit_start;
        r_free_idx  <= n_free_idx;
        r_bucket    <= n_bucket;
        r_res       <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTH
    // Each event yields one beat, and beats are never back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result beats on two cycles in a row");

    // An accepted event makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("event accepted without the block going busy");

    // A start result and a stop result never mix their flags.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($countones({o_result.stored, o_result.table_full,
                                  o_result.matched}) <= 1))
        else $error("result beat carries more than one outcome flag");

    // Without a match the bucket fields stay zero.
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.matched) |->
            ((o_result.bucket == '0) && (o_result.bucket_count == '0)))
        else $error("bucket fields set on a beat without a match");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for keyed_latency_log2_histogram_unit: offers start and stop
// events, takes each expected beat from a directed row or a local model of the key table
// and histogram, and compares the beats in order. Depends on kllh_pkg and the unit's RTL.
module tb;
    import kllh_pkg::*;

    localparam int Slots        = TableEntriesDef;
    localparam int Buckets      = HistBucketsDef;
    localparam int RandomEvents = 1080;
    localparam int ReportLimit  = 10;
    // Sized for the slowest legal run: every event a matched stop behind the longest
    // sender gap, plus the clearing pass; the limit is several times that.
    localparam int CycleLimit   = 1_500_000;
    localparam int DrainCycles  = 200;

    localparam logic [DataW-1:0] AllOnes = '1;
    localparam logic [DataW-1:0] KeyA    = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [DataW-1:0] KeyB    = 64'h5555_5555_5555_5555;
    localparam logic [DataW-1:0] MidTime = 64'h8000_0000_0000_0000;

    typedef struct {
        t_in  ev;
        bit   typed;
        t_res want;
    } t_probe_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  i_item  = '0;
    logic o_strobe;
    t_res o_result;

    // A typed expectation rides along with the event it belongs to, so the monitor
    // samples it at the same edge that accepts the event.
    logic row_typed = 1'b0;
    t_res row_want  = '0;

    // Local copy of the key table and the histogram.
    logic             slot_valid [Slots];
    logic [DataW-1:0] slot_key   [Slots];
    logic [DataW-1:0] slot_start [Slots];
    logic [DataW-1:0] hist_count [Buckets];
    t_res             pending_beats [$];

    // Stimulus-side view of which keys are open, with their start times.
    logic [DataW-1:0] live_keys   [$];
    logic [DataW-1:0] live_starts [$];

    int mismatches = 0;
    int beats_seen = 0;
    int accepted   = 0;
    int burst_left = 0;
    int n_stored   = 0;
    int n_dropped  = 0;
    int n_matched  = 0;
    int n_missed   = 0;
    logic [Buckets-1:0] buckets_hit = '0;

    keyed_latency_log2_histogram_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out the beat that one event causes and updates the local state.
    function automatic t_res latency_outcome(t_in ev);
        t_res             r;
        int               hit;
        int               lead;
        logic [DataW-1:0] span;
        logic [DataW-1:0] micros;
        r   = '0;
        hit = -1;
        for (int i = 0; i < Slots; i++) begin
            if (hit < 0 && slot_valid[i] && slot_key[i] == ev.requester) hit = i;
        end
        if (ev.kind == KindStart) begin
            // A new key takes the lowest free entry; a present key is simply rewritten.
            for (int i = 0; i < Slots; i++) begin
                if (hit < 0 && !slot_valid[i]) hit = i;
            end
            if (hit >= 0) begin
                slot_valid[hit] = 1'b1;
                slot_key[hit]   = ev.requester;
                slot_start[hit] = ev.time_ns;
                r.stored        = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end else if (hit >= 0) begin
            // The difference wraps, so a timestamp going backwards gives a huge latency.
            span            = ev.time_ns - slot_start[hit];
            micros          = span / NsPerUs;
            slot_valid[hit] = 1'b0;
            if (micros == 0) micros = DataW'(1);
            lead = 0;
            for (int k = 1; k < DataW; k++) begin
                if (micros[k]) lead = k;
            end
            if (lead > Buckets - 1) lead = Buckets - 1;
            hist_count[lead] = hist_count[lead] + 1'b1;
            r.matched        = 1'b1;
            r.bucket         = BucketW'(lead);
            r.bucket_count   = hist_count[lead];
        end
        return r;
    endfunction

    function automatic t_res beat(int s, int f, int m, int b, int c);
        t_res r;
        r              = '0;
        r.stored       = 1'(s);
        r.table_full   = 1'(f);
        r.matched      = 1'(m);
        r.bucket       = BucketW'(b);
        r.bucket_count = DataW'(c);
        return r;
    endfunction

    function automatic t_probe_row row(logic k, logic [DataW-1:0] key, logic [DataW-1:0] t,
                                       int typed, t_res want);
        t_probe_row p;
        p.ev.kind      = k;
        p.ev.requester = key;
        p.ev.time_ns   = t;
        p.typed        = (typed != 0);
        p.want         = want;
        return p;
    endfunction

    task automatic flag_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
        mismatches++;
        if (mismatches <= ReportLimit)
            $display("tb: beat %0d, %s expected %h, got %h", beats_seen, field, want, got);
    endtask

    // Checks result beats and records the expectation of every accepted event.
    always @(posedge i_clk) begin : monitor
        t_res want;
        t_res outcome;
        if (!i_rst_n) begin
            for (int i = 0; i < Slots; i++) slot_valid[i] = 1'b0;
            for (int b = 0; b < Buckets; b++) hist_count[b] = '0;
            pending_beats.delete();
        end else begin
            if (o_strobe) begin
                beats_seen++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("tb: beat %0d arrived with nothing expected: %p",
                                 beats_seen, o_result);
                end else begin
                    want = pending_beats.pop_front();
                    if (o_result.stored !== want.stored)
                        flag_field("stored", DataW'(want.stored),
                                   DataW'(o_result.stored));
                    if (o_result.table_full !== want.table_full)
                        flag_field("table_full", DataW'(want.table_full),
                                   DataW'(o_result.table_full));
                    if (o_result.matched !== want.matched)
                        flag_field("matched", DataW'(want.matched),
                                   DataW'(o_result.matched));
                    if (o_result.bucket !== want.bucket)
                        flag_field("bucket", DataW'(want.bucket),
                                   DataW'(o_result.bucket));
                    if (o_result.bucket_count !== want.bucket_count)
                        flag_field("bucket_count", want.bucket_count, o_result.bucket_count);
                end
            end
            if (start && !busy) begin
                outcome = latency_outcome(i_item);
                if (outcome.stored) n_stored++;
                if (outcome.table_full) n_dropped++;
                if (outcome.matched) begin
                    n_matched++;
                    buckets_hit[outcome.bucket] = 1'b1;
                end
                if (i_item.kind == KindStop && !outcome.matched) n_missed++;
                pending_beats.push_back(row_typed ? row_want : outcome);
            end
        end
    end

    // Offers one event and waits for the edge that takes it. The sender works in
    // bursts: within a burst start stays high, between bursts it drops for a while.
    task automatic offer(t_in ev, bit typed, t_res want);
        int gap;
        start     <= 1'b1;
        i_item    <= ev;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge i_clk); while (busy);
        accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 180) : $urandom_range(1, 40);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 7);
        end
    endtask

    function automatic int live_index(logic [DataW-1:0] key);
        int idx;
        idx = -1;
        foreach (live_keys[i]) begin
            if (idx < 0 && live_keys[i] == key) idx = i;
        end
        return idx;
    endfunction

    // Start event for a key that is, almost always, not open yet.
    task automatic launch_fresh_key();
        t_in ev;
        int  idx;
        ev.kind      = KindStart;
        ev.requester = ($urandom_range(0, 3) == 0) ? DataW'($urandom_range(0, 255))
                                                   : {$urandom(), $urandom()};
        ev.time_ns   = {$urandom(), $urandom()};
        idx          = live_index(ev.requester);
        if (idx >= 0) begin
            live_starts[idx] = ev.time_ns;
        end else if (live_keys.size() < Slots) begin
            live_keys.push_back(ev.requester);
            live_starts.push_back(ev.time_ns);
        end
        offer(ev, 1'b0, '0);
    endtask

    // Start event that rewrites the timestamp of an open key.
    task automatic restart_live_key();
        t_in ev;
        int  idx;
        idx              = $urandom_range(0, live_keys.size() - 1);
        ev.kind          = KindStart;
        ev.requester     = live_keys[idx];
        ev.time_ns       = {$urandom(), $urandom()};
        live_starts[idx] = ev.time_ns;
        offer(ev, 1'b0, '0);
    endtask

    // Stop event that closes an open key after a latency of random magnitude.
    task automatic finish_live_key();
        t_in              ev;
        int               idx;
        int               pick;
        logic [DataW-1:0] span;
        idx  = $urandom_range(0, live_keys.size() - 1);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            span = {$urandom(), $urandom()};
        else if (pick < 4)
            span = DataW'($urandom_range(0, 4000));
        else
            span = {$urandom(), $urandom()} >> $urandom_range(0, 63);
        ev.kind      = KindStop;
        ev.requester = live_keys[idx];
        ev.time_ns   = live_starts[idx] + span;
        live_keys.delete(idx);
        live_starts.delete(idx);
        offer(ev, 1'b0, '0);
    endtask

    initial begin : stimulus
        t_probe_row directed [$];
        t_in        stray;
        int         pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events: misses on an empty table, overwrite, sub-microsecond and
        // exactly one-microsecond latencies, wrapping timestamps, extreme keys and times,
        // out-of-order stops and a near-miss key.
        directed.push_back(row(KindStop,  '0,        '0,       1, beat(0, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  AllOnes,   AllOnes,  1, beat(0, 0, 0, 0, 0)));
        directed.push_back(row(KindStart, '0,        '0,       1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStart, '0,        64'd5,    1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  '0,        64'd1004, 1, beat(0, 0, 1, 0, 1)));
        directed.push_back(row(KindStop,  '0,        '0,       1, beat(0, 0, 0, 0, 0)));
        directed.push_back(row(KindStart, AllOnes,   AllOnes,  1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  AllOnes,   '0,       1, beat(0, 0, 1, 0, 2)));
        directed.push_back(row(KindStart, 64'd1,     '0,       1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  64'd1,     AllOnes,  0, '0));
        directed.push_back(row(KindStart, 64'd2,     64'd1000, 1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  64'd2,     64'd2999, 1, beat(0, 0, 1, 0, 3)));
        directed.push_back(row(KindStart, 64'd5,     '0,       1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  64'd5,     64'd1000, 1, beat(0, 0, 1, 0, 4)));
        directed.push_back(row(KindStart, 64'd3,     MidTime,  1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  64'd3,     MidTime + 64'd2000, 0, '0));
        directed.push_back(row(KindStart, KeyA,      64'd100,  1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStart, KeyB,      64'd200,  1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  KeyA ^ 64'd1, 64'd300, 1, beat(0, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  KeyB,      64'd1_000_200, 0, '0));
        directed.push_back(row(KindStop,  KeyA,      64'd100 + (64'd1 << 40), 0, '0));
        directed.push_back(row(KindStop,  KeyA,      AllOnes,  1, beat(0, 0, 0, 0, 0)));
        directed.push_back(row(KindStart, 64'd4,     64'd10,   1, beat(1, 0, 0, 0, 0)));
        directed.push_back(row(KindStop,  64'd4,     64'd5,    0, '0));
        foreach (directed[i]) offer(directed[i].ev, directed[i].typed, directed[i].want);

        // Random events. Mostly well-formed start/stop traffic on open keys; now and then
        // the table is filled to the brim, overrun and then partly or wholly drained.
        while (accepted < directed.size() + RandomEvents) begin
            if ($urandom_range(0, 7) == 0) begin
                while (live_keys.size() < Slots) launch_fresh_key();
                repeat (3) launch_fresh_key();
                repeat (2) restart_live_key();
                repeat ($urandom_range(32, Slots)) finish_live_key();
            end else begin
                repeat (20) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35 || (pick < 85 && live_keys.size() == 0)) begin
                        launch_fresh_key();
                    end else if (pick < 45) begin
                        restart_live_key();
                    end else if (pick < 85) begin
                        finish_live_key();
                    end else begin
                        // Stop for a key that was never opened.
                        stray.kind      = KindStop;
                        stray.requester = {$urandom(), $urandom()};
                        stray.time_ns   = {$urandom(), $urandom()};
                        offer(stray, 1'b0, '0);
                    end
                end
            end
        end

        start <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("tb: %0d events: %0d starts stored, %0d dropped on a full table,",
                 accepted, n_stored, n_dropped);
        $display("tb: %0d stops matched over %0d buckets, %0d stops without a match",
                 n_matched, $countones(buckets_hit), n_missed);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
